[rtl/pzfl_pkg.sv]
`timescale 1ns / 1ps
// Package holding the shared types and constants of the point-in-zone flag lookup.
package pzfl_pkg;

	localparam int MAX_ZONES = 4096;
	localparam int ZONE_AW   = $clog2(MAX_ZONES);
	localparam int CNT_W     = $clog2(MAX_ZONES + 1);

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [11:0]        entry_index;
		logic signed [15:0] corner_x;
		logic signed [15:0] corner_y;
		logic [31:0]        edge_one;
		logic [31:0]        edge_two;
		logic [31:0]        z_bounds;
		logic [15:0]        zone_flags;
		logic signed [19:0] point_x;
		logic signed [19:0] point_y;
		logic signed [19:0] point_z;
	} item_t;

	typedef struct packed {
		logic [15:0] merged_flags;
		logic        any_hit;
	} result_t;

	typedef struct packed {
		logic [15:0] flags;
		logic [31:0] z_bounds;
		logic [31:0] edge_two;
		logic [31:0] edge_one;
		logic [15:0] corner_y;
		logic [15:0] corner_x;
	} zone_t;

	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] z;
	} point_t;

	typedef struct packed {
		logic        valid;
		logic        hit;
		logic [15:0] flags;
	} match_t;

endpackage

[rtl/pzfl_ram.sv]
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous RAM with a registered read.
module pzfl_ram #(
	parameter int AW = 12,
	parameter int DW = 144
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/pzfl_zone_eval.sv]
`timescale 1ns / 1ps
// Three-stage pipeline that tests one zone entry against the query point.
module pzfl_zone_eval import pzfl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   zone_valid,
	input  zone_t  zone,
	input  point_t point,
	output match_t match,
	output logic   busy
);

	logic signed [15:0] cx, cy, ax, ay, bx, by, zlo, zhi;
	logic signed [19:0] zlo_q4, zhi_q4;
	logic signed [20:0] dx, dy;
	logic               zok;

	logic               v_s2, v_s3, v_s4;
	logic signed [20:0] dx_s2, dy_s2;
	logic signed [15:0] ax_s2, ay_s2, bx_s2, by_s2;
	logic               zok_s2, zok_s3;
	logic [15:0]        flags_s2, flags_s3, flags_s4;
	logic signed [36:0] pax_s3, pay_s3, pbx_s3, pby_s3;
	logic signed [31:0] sax_s3, say_s3, sbx_s3, sby_s3;
	logic               hit_s4;

	logic signed [37:0] p1, p2, l1, l2;
	logic signed [32:0] q1, q2;

	assign cx  = zone.corner_x;
	assign cy  = zone.corner_y;
	assign ax  = zone.edge_one[15:0];
	assign ay  = zone.edge_one[31:16];
	assign bx  = zone.edge_two[15:0];
	assign by  = zone.edge_two[31:16];
	assign zlo = zone.z_bounds[15:0];
	assign zhi = zone.z_bounds[31:16];

	assign zlo_q4 = {zlo, 4'b0000};
	assign zhi_q4 = {zhi, 4'b0000};
	assign zok    = (zlo_q4 < point.z) && (zhi_q4 > point.z);
	assign dx     = {point.x[19], point.x} - {cx[15], cx, 4'b0000};
	assign dy     = {point.y[19], point.y} - {cy[15], cy, 4'b0000};

	always_ff @(posedge clk) begin
		dx_s2    <= dx;
		dy_s2    <= dy;
		ax_s2    <= ax;
		ay_s2    <= ay;
		bx_s2    <= bx;
		by_s2    <= by;
		zok_s2   <= zok;
		flags_s2 <= zone.flags;
	end

	always_ff @(posedge clk) begin
		pax_s3   <= ax_s2 * dx_s2;
		pay_s3   <= ay_s2 * dy_s2;
		pbx_s3   <= bx_s2 * dx_s2;
		pby_s3   <= by_s2 * dy_s2;
		sax_s3   <= ax_s2 * ax_s2;
		say_s3   <= ay_s2 * ay_s2;
		sbx_s3   <= bx_s2 * bx_s2;
		sby_s3   <= by_s2 * by_s2;
		zok_s3   <= zok_s2;
		flags_s3 <= flags_s2;
	end

	assign p1 = {pax_s3[36], pax_s3} + {pay_s3[36], pay_s3};
	assign p2 = {pbx_s3[36], pbx_s3} + {pby_s3[36], pby_s3};
	assign q1 = {sax_s3[31], sax_s3} + {say_s3[31], say_s3};
	assign q2 = {sbx_s3[31], sbx_s3} + {sby_s3[31], sby_s3};
	assign l1 = {q1[32], q1, 4'b0000};
	assign l2 = {q2[32], q2, 4'b0000};

	always_ff @(posedge clk) begin
		hit_s4   <= zok_s3 && !p1[37] && (p1 <= l1) && !p2[37] && (p2 <= l2);
		flags_s4 <= flags_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= zone_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign match.valid = v_s4;
	assign match.hit   = hit_s4;
	assign match.flags = flags_s4;
	assign busy        = v_s2 || v_s3 || v_s4;

endmodule

[rtl/point_in_zone_flag_lookup_core.sv]
`timescale 1ns / 1ps
// Top level of the point-in-zone flag lookup: zone RAM, scan control and result register.
// A write item stores one zone in the zone RAM; it gives no result.
// A query item reads the first N = min(zone_count, 4096) entries, one per cycle through the
// single read port of the zone RAM, and each entry then passes a three-stage test pipeline;
// the result is loaded into the result register once that pipeline has drained. One
// item is worked on at a time and the input is not ready from a query's transfer until its
// result is loaded. The result register lets the next item be taken while an earlier result
// still waits; a later query that finishes before that result is taken holds its own result
// and the input until the earlier one leaves.
module point_in_zone_flag_lookup_core import pzfl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   zone_count_q;
	logic [CNT_W-1:0]   limit;
	logic [CNT_W-1:0]   cnt_q;
	logic               rd_v_q;
	logic               rd_en;
	logic               wr_en;
	logic               item_xfer;
	logic               busy_pipe;
	logic               eval_busy;
	point_t             point_q;
	zone_t              wr_zone;
	zone_t              rd_zone;
	match_t             match;
	logic [15:0]        flags_q;
	logic               hit_q;
	logic               out_free;
	logic               result_load;

	assign cfg_ready   = 1'b1;
	assign item_ready  = (state_q == ST_IDLE);
	assign item_xfer   = item_valid && item_ready;
	assign wr_en       = item_xfer && (item.kind == KIND_WRITE);
	assign limit       = (zone_count_q > CNT_W'(MAX_ZONES)) ? CNT_W'(MAX_ZONES) : zone_count_q;
	assign rd_en       = (state_q == ST_SCAN) && (cnt_q < limit);
	assign busy_pipe   = rd_v_q || eval_busy;
	assign out_free    = !result_valid || result_ready;
	assign result_load = (state_q == ST_DONE) && out_free;

	assign wr_zone.flags    = item.zone_flags;
	assign wr_zone.z_bounds = item.z_bounds;
	assign wr_zone.edge_two = item.edge_two;
	assign wr_zone.edge_one = item.edge_one;
	assign wr_zone.corner_y = item.corner_y;
	assign wr_zone.corner_x = item.corner_x;

	pzfl_ram #(
		.AW(ZONE_AW),
		.DW($bits(zone_t))
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (item.entry_index[ZONE_AW-1:0]),
		.wr_data (wr_zone),
		.rd_en   (rd_en),
		.rd_addr (cnt_q[ZONE_AW-1:0]),
		.rd_data (rd_zone)
	);

	pzfl_zone_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.zone_valid (rd_v_q),
		.zone       (rd_zone),
		.point      (point_q),
		.match      (match),
		.busy       (eval_busy)
	);

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			point_q.x <= item.point_x;
			point_q.y <= item.point_y;
			point_q.z <= item.point_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			zone_count_q <= '0;
			cnt_q        <= '0;
			rd_v_q       <= 1'b0;
			flags_q      <= '0;
			hit_q        <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			rd_v_q <= rd_en;
			if (cfg_valid && cfg_ready) begin
				zone_count_q <= cfg_data;
			end
			if (result_load) begin
				result_valid <= 1'b1;
			end else if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			if (match.valid && match.hit) begin
				flags_q <= flags_q | match.flags;
				hit_q   <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer && (item.kind == KIND_QUERY)) begin
						cnt_q   <= '0;
						flags_q <= '0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!busy_pipe) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						result.merged_flags <= flags_q;
						result.any_hit      <= hit_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Reads never run past the active zone count.
	assert property (@(posedge clk) disable iff (!arst_n) rd_en |-> (cnt_q < limit))
		else $error("zone read beyond the active count");

	// Zone tests only complete while a query is being scanned.
	assert property (@(posedge clk) disable iff (!arst_n) match.valid |-> (state_q == ST_SCAN))
		else $error("zone test completed outside a scan");

	// A new result only appears on leaving the done state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	// A result never reports flags without a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.any_hit) |-> (result.merged_flags == '0))
		else $error("flags reported without a hit");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for the point-in-zone flag lookup: random and directed writes and queries.
module testbench;
	import pzfl_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int IDLE_SETTLE    = 16;

	class zone_scoreboard;
		zone_t       zones [MAX_ZONES];
		bit          stored [MAX_ZONES];
		int unsigned zone_count;
		result_t     awaited [$];
		int unsigned errors;

		function void set_zone_count(logic [12:0] value);
			zone_count = value;
		endfunction

		function int unsigned active_zones();
			return (zone_count > MAX_ZONES) ? MAX_ZONES : zone_count;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function int unsigned stored_prefix();
			int unsigned n;
			n = 0;
			while (n < MAX_ZONES && stored[n])
				n++;
			return n;
		endfunction

		function result_t lookup_point(item_t q);
			result_t     found;
			zone_t       zn;
			int unsigned i;
			longint      px, py, pz, dx, dy, ax, ay, bx, by, zlo, zhi, p1, p2, l1, l2;
			found = '0;
			px = longint'($signed(q.point_x));
			py = longint'($signed(q.point_y));
			pz = longint'($signed(q.point_z));
			for (i = 0; i < active_zones(); i++) begin
				zn = zones[i];
				zlo = longint'($signed(zn.z_bounds[15:0])) * 16;
				zhi = longint'($signed(zn.z_bounds[31:16])) * 16;
				if (zlo < pz && zhi > pz) begin
					ax = longint'($signed(zn.edge_one[15:0]));
					ay = longint'($signed(zn.edge_one[31:16]));
					bx = longint'($signed(zn.edge_two[15:0]));
					by = longint'($signed(zn.edge_two[31:16]));
					dx = px - longint'($signed(zn.corner_x)) * 16;
					dy = py - longint'($signed(zn.corner_y)) * 16;
					p1 = ax * dx + ay * dy;
					p2 = bx * dx + by * dy;
					l1 = (ax * ax + ay * ay) * 16;
					l2 = (bx * bx + by * by) * 16;
					if (p1 >= 0 && p1 <= l1 && p2 >= 0 && p2 <= l2) begin
						found.merged_flags = found.merged_flags | zn.flags;
						found.any_hit = 1'b1;
					end
				end
			end
			return found;
		endfunction

		function void note_item(item_t it);
			if (it.kind == KIND_WRITE) begin
				zones[it.entry_index].flags    = it.zone_flags;
				zones[it.entry_index].z_bounds = it.z_bounds;
				zones[it.entry_index].edge_two = it.edge_two;
				zones[it.entry_index].edge_one = it.edge_one;
				zones[it.entry_index].corner_y = it.corner_y;
				zones[it.entry_index].corner_x = it.corner_x;
				stored[it.entry_index] = 1'b1;
			end else begin
				awaited = {awaited, lookup_point(it)};
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				$error("Result with no query outstanding: merged_flags %h, any_hit %b",
					got.merged_flags, got.any_hit);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.merged_flags !== want.merged_flags) begin
				$error("merged_flags: expected %h, actual %h",
					want.merged_flags, got.merged_flags);
				errors++;
			end
			if (got.any_hit !== want.any_hit) begin
				$error("any_hit: expected %b, actual %b", want.any_hit, got.any_hit);
				errors++;
			end
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [12:0] cfg_data     = '0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	item_t       item         = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;

	zone_scoreboard sb;
	int unsigned    burst_left  = 1;
	bit             valid_held  = 1'b0;
	int unsigned    quiet_cycles = 0;
	logic [15:0]    stall_mask  = '1;
	logic [5:0]     stall_tick  = '0;

	point_in_zone_flag_lookup_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #4 clk = ~clk;

	// The receiver drives ready from a 16-bit random pattern and picks a fresh one when its tick counter wraps.
	always @(posedge clk) begin
		if (stall_tick == 0) begin
			case ($urandom_range(3, 0))
				0: stall_mask = '1;
				1: stall_mask = 16'($urandom);
				2: stall_mask = 16'($urandom | $urandom);
				default: stall_mask = 16'($urandom & $urandom);
			endcase
		end
		result_ready <= stall_mask[stall_tick[3:0]];
		stall_tick++;
	end

	always @(posedge clk) begin
		if (result_valid === 1'b1 && result_ready === 1'b1)
			sb.check_result(result);
		if ((item_valid && item_ready) === 1'b1 || (cfg_valid && cfg_ready) === 1'b1
				|| (result_valid && result_ready) === 1'b1) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic item_t noise_item(logic kind);
		item_t it;
		it.kind        = kind;
		it.entry_index = 12'($urandom);
		it.corner_x    = 16'($urandom);
		it.corner_y    = 16'($urandom);
		it.edge_one    = $urandom;
		it.edge_two    = $urandom;
		it.z_bounds    = $urandom;
		it.zone_flags  = 16'($urandom);
		it.point_x     = 20'($urandom);
		it.point_y     = 20'($urandom);
		it.point_z     = 20'($urandom);
		return it;
	endfunction

	function automatic item_t zone_write(int unsigned slot);
		item_t it;
		int    ax, ay, bx, by, k, zlo, zhi;
		it = noise_item(KIND_WRITE);
		it.entry_index = 12'(slot);
		if ($urandom_range(4, 0) == 0)
			return it;
		ax = int'($urandom_range(600, 0)) - 300;
		ay = int'($urandom_range(600, 0)) - 300;
		if ($urandom_range(2, 0) != 0) begin
			k  = int'($urandom_range(3, 1));
			bx = -ay * k;
			by = ax * k;
		end else begin
			bx = int'($urandom_range(600, 0)) - 300;
			by = int'($urandom_range(600, 0)) - 300;
		end
		zlo = int'($urandom_range(2000, 0)) - 1000;
		if ($urandom_range(7, 0) == 0)
			zhi = zlo - int'($urandom_range(3, 0));
		else
			zhi = zlo + int'($urandom_range(300, 1));
		it.corner_x = 16'(int'($urandom_range(4000, 0)) - 2000);
		it.corner_y = 16'(int'($urandom_range(4000, 0)) - 2000);
		it.edge_one = {16'(ay), 16'(ax)};
		it.edge_two = {16'(by), 16'(bx)};
		it.z_bounds = {16'(zhi), 16'(zlo)};
		return it;
	endfunction

	function automatic item_t directed_zone(int slot, int cx, int cy, int ax, int ay,
			int bx, int by, int zmin, int zmax, int flags);
		item_t it;
		it = noise_item(KIND_WRITE);
		it.entry_index = 12'(slot);
		it.corner_x    = 16'(cx);
		it.corner_y    = 16'(cy);
		it.edge_one    = {16'(ay), 16'(ax)};
		it.edge_two    = {16'(by), 16'(bx)};
		it.z_bounds    = {16'(zmax), 16'(zmin)};
		it.zone_flags  = 16'(flags);
		return it;
	endfunction

	function automatic item_t point_query(int px, int py, int pz);
		item_t it;
		it = noise_item(KIND_QUERY);
		it.point_x = 20'(px);
		it.point_y = 20'(py);
		it.point_z = 20'(pz);
		return it;
	endfunction

	// Aims the point into a random active zone, sometimes just outside it or on a z bound.
	function automatic item_t aimed_query();
		item_t it;
		zone_t zn;
		int    span, a, b, px, py, zlo, zhi, pz;
		it = noise_item(KIND_QUERY);
		span = int'(sb.active_zones());
		if (span == 0)
			return it;
		zn = sb.zones[$urandom_range(span - 1, 0)];
		a = int'($urandom_range(18, 0)) - 1;
		b = int'($urandom_range(18, 0)) - 1;
		px = int'($signed(zn.corner_x)) * 16 + a * int'($signed(zn.edge_one[15:0]))
			+ b * int'($signed(zn.edge_two[15:0]));
		py = int'($signed(zn.corner_y)) * 16 + a * int'($signed(zn.edge_one[31:16]))
			+ b * int'($signed(zn.edge_two[31:16]));
		zlo = int'($signed(zn.z_bounds[15:0])) * 16;
		zhi = int'($signed(zn.z_bounds[31:16])) * 16;
		case ($urandom_range(9, 0))
			0: pz = zlo;
			1: pz = zhi;
			default: pz = (zhi - zlo > 1) ? zlo + 1 + int'($urandom_range(zhi - zlo - 2, 0)) : zlo;
		endcase
		it.point_x = 20'(px);
		it.point_y = 20'(py);
		it.point_z = 20'(pz);
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int unsigned gap;
		item <= it;
		item_valid <= 1'b1;
		valid_held = 1'b1;
		do @(posedge clk); while (item_ready !== 1'b1);
		sb.note_item(it);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(12, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap != 0) begin
				item_valid <= 1'b0;
				valid_held = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops sending and waits until every query has been answered and any write has landed.
	task automatic settle();
		if (valid_held) begin
			item_valid <= 1'b0;
			valid_held = 1'b0;
		end
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_count(input int unsigned value);
		cfg_data <= 13'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_zone_count(13'(value));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned round, top, pick;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_count(0);
		send_item(point_query(524287, 524287, 524287));
		send_item(point_query(-524288, -524288, -524288));
		send_item(directed_zone(0, 0, 0, 10, 0, 0, 10, 0, 10, 16'h0001));
		send_item(directed_zone(1, 0, 0, 10, 0, 0, 10, -5, 5, 16'h8000));
		send_item(directed_zone(2, 100, 100, 0, 0, 0, 0, 1000, 1002, 16'h0100));
		send_item(directed_zone(3, 0, 0, 10, 0, 0, 10, 5, 5, 16'h0010));
		send_item(directed_zone(4, -32768, -32768, 32767, -32768, -32768, 32767,
			-32768, 32767, 16'h0040));
		send_item(directed_zone(5, 32767, 32767, 1, 1, -1, 1, 32767, -32768, 16'hFFFF));
		send_item(noise_item(KIND_WRITE) | item_t'({1'b0, 12'hFFF, 204'b0}));
		settle();

		write_count(6);
		send_item(point_query(0, 0, 16));
		send_item(point_query(160, 160, 16));
		send_item(point_query(161, 160, 16));
		send_item(point_query(-1, -1, 16));
		send_item(point_query(80, 80, 0));
		send_item(point_query(80, 80, 160));
		send_item(point_query(80, 80, 159));
		send_item(point_query(80, 80, 80));
		send_item(point_query(-524288, 524287, 16010));
		settle();

		for (round = 0; round < 5; round++) begin
			repeat ($urandom_range(12, 4))
				send_item(zone_write(sb.stored_prefix()));
			settle();
			top = sb.stored_prefix();
			case (round)
				0: write_count(top);
				1: write_count(0);
				2: write_count(1);
				default: write_count($urandom_range(top, 1));
			endcase
			repeat (16) begin
				pick = $urandom_range(99, 0);
				if (pick < 60)
					send_item(aimed_query());
				else if (pick < 75)
					send_item(zone_write($urandom_range(top, 0)));
				else if (pick < 90)
					send_item(noise_item(KIND_QUERY));
				else
					send_item(noise_item(KIND_WRITE));
				if ($urandom_range(24, 0) == 0)
					settle();
			end
			settle();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
